@@ design/gdcm_pkg.sv @@
// Package with the transaction types, constants and direction tables of the clearance map.
`default_nettype none

package gdcm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SIDE_DEF = 128;
    localparam int PROX_CAP_DEF = 20;

    // Eight directions, eight bits of run length each.
    localparam int NUM_DIRS = 8;
    localparam int RUN_W    = 8;

    // Command codes; the last one has no function and answers with an all-zero result.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // Configuration register indexes.
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    // Direction codes, in the order the runs are packed into a tile word.
    localparam logic [2:0] DIR_N  = 3'd0;
    localparam logic [2:0] DIR_S  = 3'd1;
    localparam logic [2:0] DIR_W  = 3'd2;
    localparam logic [2:0] DIR_E  = 3'd3;
    localparam logic [2:0] DIR_NW = 3'd4;
    localparam logic [2:0] DIR_NE = 3'd5;
    localparam logic [2:0] DIR_SW = 3'd6;
    localparam logic [2:0] DIR_SE = 3'd7;

    // Input transaction.
    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] tile_x;
        logic [6:0] tile_y;
        logic [4:0] rect_w;
        logic [4:0] rect_h;
        logic       walkable;
    } command_t;

    // Result transaction.
    typedef struct packed {
        logic       changed;
        logic       tile_walkable;
        logic [4:0] proximity;
        logic [8:0] passage_width;
    } result_t;

    // The k-th direction handled by the forward pass (N, W, NW, NE) or the backward pass.
    function automatic logic [2:0] dir_of(input logic bwd, input logic [1:0] k);
        logic [2:0] d;
        case (k)
            2'd0:    d = bwd ? DIR_S  : DIR_N;
            2'd1:    d = bwd ? DIR_E  : DIR_W;
            2'd2:    d = bwd ? DIR_SW : DIR_NW;
            default: d = bwd ? DIR_SE : DIR_NE;
        endcase
        return d;
    endfunction

    // Column step of a direction.
    function automatic logic signed [1:0] step_dx(input logic [2:0] d);
        logic signed [1:0] s;
        case (d)
            DIR_W, DIR_NW, DIR_SW: s = -2'sd1;
            DIR_E, DIR_NE, DIR_SE: s = 2'sd1;
            default:               s = 2'sd0;
        endcase
        return s;
    endfunction

    // Row step of a direction.
    function automatic logic signed [1:0] step_dy(input logic [2:0] d);
        logic signed [1:0] s;
        case (d)
            DIR_N, DIR_NW, DIR_NE: s = -2'sd1;
            DIR_S, DIR_SW, DIR_SE: s = 2'sd1;
            default:               s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/gdcm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gdcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/grid_directional_clearance_map_core.sv @@
// Top level of the eight-direction clearance map: sequencer, grid and run memories.
`default_nettype none

// Keeps a walkability grid and eight directional runs per tile. After reset the block
// clears both memories, one tile per cycle, with busy high; configuration writes are
// taken during that time. A start is taken when busy is low, and exactly one result
// follows, marked by done for one cycle; the result cannot be held off. A load or an
// update works through the clipped rectangle tile by tile, each tile a read-modify-write
// through the single grid read port. An update that changes a tile then recomputes the
// runs in a forward and a backward scan of the map in use; for each tile and pass the one
// read port of the run memory fetches four neighbor words and the tile's own word.
module grid_directional_clearance_map_core #(
    parameter int MAX_SIDE = gdcm_pkg::MAX_SIDE_DEF,
    parameter int PROX_CAP = gdcm_pkg::PROX_CAP_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  gdcm_pkg::command_t  command,
    output logic                busy,
    output logic                done,
    output gdcm_pkg::result_t   result,
    input  wire                 cfg_we,
    input  wire                 cfg_index,
    input  wire [7:0]           cfg_data
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = ($clog2(MAX_SIDE) + 2 > 9) ? $clog2(MAX_SIDE) + 2 : 9;
    localparam int WORD_W = gdcm_pkg::NUM_DIRS * gdcm_pkg::RUN_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RECT  = 3'd2;
    localparam logic [2:0] ST_FWD   = 3'd3;
    localparam logic [2:0] ST_BWD   = 3'd4;
    localparam logic [2:0] ST_QRY   = 3'd5;

    localparam logic [2:0] PH_OWN   = 3'd4;
    localparam logic [2:0] PH_LAST  = 3'd6;

    // Registers.
    logic [2:0]           state_reg, state_next;
    logic [2:0]           phase_reg, phase_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [7:0]           mw_reg, mh_reg;
    logic [1:0]           cmd_reg, cmd_next;
    logic [CW-1:0]        tx_reg, tx_next;
    logic [CW-1:0]        xe_reg, xe_next;
    logic [CW-1:0]        ye_reg, ye_next;
    logic                 wv_reg, wv_next;
    logic                 any_reg, any_next;
    logic [CW-1:0]        x_reg, x_next;
    logic [CW-1:0]        y_reg, y_next;
    logic                 nv_reg, nv_next;
    logic                 walk_reg, walk_next;
    logic [7:0]           nb_reg [4];
    logic [7:0]           nb_next [4];
    logic [WORD_W-1:0]    own_reg, own_next;
    logic                 done_reg, done_next;
    gdcm_pkg::result_t    res_reg, res_next;

    // Memory ports.
    logic                 g_we, r_we;
    logic [AW-1:0]        g_waddr, g_raddr, r_waddr, r_raddr;
    logic                 g_wdata, g_rdata;
    logic [WORD_W-1:0]    r_wdata, r_rdata;

    // Map size in use, with zero read as one and oversize read as the maximum.
    logic [CW-1:0]        wu, hu;
    always_comb
    begin
        if (mw_reg == 8'd0)
            wu = CW'(1);
        else if (CW'(mw_reg) > CW'(MAX_SIDE))
            wu = CW'(MAX_SIDE);
        else
            wu = CW'(mw_reg);
        if (mh_reg == 8'd0)
            hu = CW'(1);
        else if (CW'(mh_reg) > CW'(MAX_SIDE))
            hu = CW'(MAX_SIDE);
        else
            hu = CW'(mh_reg);
    end

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] ax, input logic [CW-1:0] ay);
        return AW'(32'(ay) * MAX_SIDE + 32'(ax));
    endfunction

    // Neighbor of the current tile for the read issued in this phase.
    logic              bwd;
    logic [2:0]        rd_dir, lt_dir;
    logic [CW-1:0]     nx, ny;
    logic              n_in;
    logic signed [1:0] sdx, sdy;
    always_comb
    begin
        bwd    = (state_reg == ST_BWD);
        rd_dir = gdcm_pkg::dir_of(bwd, phase_reg[1:0]);
        lt_dir = gdcm_pkg::dir_of(bwd, 2'(phase_reg - 3'd1));
        sdx    = gdcm_pkg::step_dx(rd_dir);
        sdy    = gdcm_pkg::step_dy(rd_dir);
        nx     = x_reg + {{(CW-2){sdx[1]}}, sdx};
        ny     = y_reg + {{(CW-2){sdy[1]}}, sdy};
        n_in   = (nx < wu) && (ny < hu);
    end

    // New tile word: the pass's four runs replace those in the stored word.
    logic [WORD_W-1:0] new_word;
    always_comb
    begin
        logic [2:0] d;
        new_word = own_reg;
        for (int k = 0; k < 4; k++)
        begin
            d = gdcm_pkg::dir_of(bwd, 2'(k));
            if (!walk_reg)
                new_word[{d, 3'b000} +: 8] = 8'd0;
            else if (nb_reg[k] == 8'hFF)
                new_word[{d, 3'b000} +: 8] = 8'hFF;
            else
                new_word[{d, 3'b000} +: 8] = nb_reg[k] + 8'd1;
        end
    end

    // Query evaluation from the tile word as it leaves the run memory.
    logic [7:0] q_prox;
    logic [8:0] q_pw;
    always_comb
    begin
        logic [8:0] s;
        q_prox = 8'(PROX_CAP);
        for (int d = 0; d < gdcm_pkg::NUM_DIRS; d++)
        begin
            if (r_rdata[d*8 +: 8] < q_prox)
                q_prox = r_rdata[d*8 +: 8];
        end
        q_pw = {1'b0, r_rdata[7:0]} + {1'b0, r_rdata[15:8]};
        s = {1'b0, r_rdata[23:16]} + {1'b0, r_rdata[31:24]};
        if (s < q_pw)
            q_pw = s;
        s = {1'b0, r_rdata[47:40]} + {1'b0, r_rdata[55:48]};
        if (s < q_pw)
            q_pw = s;
        s = {1'b0, r_rdata[39:32]} + {1'b0, r_rdata[63:56]};
        if (s < q_pw)
            q_pw = s;
    end

    // Sequencer.
    always_comb
    begin
        logic [CW-1:0] ctx, cty, cxe, cye;
        logic          diff;
        state_next = state_reg;
        phase_next = phase_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        tx_next    = tx_reg;
        xe_next    = xe_reg;
        ye_next    = ye_reg;
        wv_next    = wv_reg;
        any_next   = any_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        nv_next    = nv_reg;
        walk_next  = walk_reg;
        nb_next    = nb_reg;
        own_next   = own_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ctx  = CW'(command.tile_x);
        cty  = CW'(command.tile_y);
        cxe  = ctx + CW'(command.rect_w);
        cye  = cty + CW'(command.rect_h);
        if (cxe > wu)
            cxe = wu;
        if (cye > hu)
            cye = hu;
        diff = (g_rdata != wv_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command.cmd;
                    tx_next    = ctx;
                    xe_next    = cxe;
                    ye_next    = cye;
                    wv_next    = command.walkable;
                    any_next   = 1'b0;
                    x_next     = ctx;
                    y_next     = cty;
                    phase_next = 3'd0;
                    res_next   = '0;
                    if (command.cmd == gdcm_pkg::CMD_LOAD || command.cmd == gdcm_pkg::CMD_UPDATE)
                    begin
                        if (ctx >= cxe || cty >= cye)
                            done_next = 1'b1;
                        else
                            state_next = ST_RECT;
                    end
                    else if (command.cmd == gdcm_pkg::CMD_QUERY && ctx < wu && cty < hu)
                        state_next = ST_QRY;
                    else
                        done_next = 1'b1;
                end
            end
            ST_RECT:
            begin
                if (phase_reg == 3'd0)
                    phase_next = 3'd1;
                else
                begin
                    phase_next = 3'd0;
                    any_next   = any_reg | diff;
                    if (x_reg + CW'(1) < xe_reg)
                        x_next = x_reg + CW'(1);
                    else
                    begin
                        x_next = tx_reg;
                        if (y_reg + CW'(1) < ye_reg)
                            y_next = y_reg + CW'(1);
                        else if (cmd_reg == gdcm_pkg::CMD_UPDATE && any_next)
                        begin
                            state_next = ST_FWD;
                            x_next     = '0;
                            y_next     = '0;
                        end
                        else
                        begin
                            state_next       = ST_IDLE;
                            done_next        = 1'b1;
                            res_next.changed = any_next;
                        end
                    end
                end
            end
            ST_FWD, ST_BWD:
            begin
                phase_next = phase_reg + 3'd1;
                nv_next    = (phase_reg < PH_OWN) ? n_in : 1'b1;
                if (phase_reg == 3'd1)
                    walk_next = g_rdata;
                if (phase_reg >= 3'd1 && phase_reg <= PH_OWN)
                    nb_next[2'(phase_reg - 3'd1)] =
                        nv_reg ? r_rdata[{lt_dir, 3'b000} +: 8] : 8'd0;
                if (phase_reg == 3'd5)
                    own_next = r_rdata;
                if (phase_reg == PH_LAST)
                begin
                    phase_next = 3'd0;
                    if (!bwd)
                    begin
                        if (x_reg == wu - CW'(1))
                        begin
                            x_next = '0;
                            if (y_reg == hu - CW'(1))
                            begin
                                state_next = ST_BWD;
                                x_next     = wu - CW'(1);
                                y_next     = hu - CW'(1);
                            end
                            else
                                y_next = y_reg + CW'(1);
                        end
                        else
                            x_next = x_reg + CW'(1);
                    end
                    else
                    begin
                        if (x_reg == '0)
                        begin
                            x_next = wu - CW'(1);
                            if (y_reg == '0)
                            begin
                                state_next       = ST_IDLE;
                                done_next        = 1'b1;
                                res_next.changed = 1'b1;
                            end
                            else
                                y_next = y_reg - CW'(1);
                        end
                        else
                            x_next = x_reg - CW'(1);
                    end
                end
            end
            ST_QRY:
            begin
                if (phase_reg == 3'd0)
                    phase_next = 3'd1;
                else
                begin
                    state_next             = ST_IDLE;
                    done_next              = 1'b1;
                    res_next.tile_walkable = g_rdata;
                    res_next.proximity     = q_prox[4:0];
                    res_next.passage_width = q_pw;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port selection.
    always_comb
    begin
        g_we    = (state_reg == ST_CLEAR) || (state_reg == ST_RECT && phase_reg == 3'd1);
        g_waddr = (state_reg == ST_CLEAR) ? clr_reg : addr_of(x_reg, y_reg);
        g_wdata = (state_reg == ST_CLEAR) ? 1'b0 : wv_reg;
        g_raddr = addr_of(x_reg, y_reg);
        r_we    = (state_reg == ST_CLEAR)
               || ((state_reg == ST_FWD || state_reg == ST_BWD) && phase_reg == PH_LAST);
        r_waddr = (state_reg == ST_CLEAR) ? clr_reg : addr_of(x_reg, y_reg);
        r_wdata = (state_reg == ST_CLEAR) ? '0 : new_word;
        if ((state_reg == ST_FWD || state_reg == ST_BWD) && phase_reg < PH_OWN && n_in)
            r_raddr = addr_of(nx, ny);
        else
            r_raddr = addr_of(x_reg, y_reg);
    end

    gdcm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gdcm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_runs_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            phase_reg <= 3'd0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            mw_reg    <= 8'd128;
            mh_reg    <= 8'd128;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_we && cfg_index == gdcm_pkg::REG_MAP_WIDTH)
                mw_reg <= cfg_data;
            if (cfg_we && cfg_index == gdcm_pkg::REG_MAP_HEIGHT)
                mh_reg <= cfg_data;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        tx_reg   <= tx_next;
        xe_reg   <= xe_next;
        ye_reg   <= ye_next;
        wv_reg   <= wv_next;
        any_reg  <= any_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        nv_reg   <= nv_next;
        walk_reg <= walk_next;
        nb_reg   <= nb_next;
        own_reg  <= own_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // A result is never flagged while a transaction is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // A query outside the map answers in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command.cmd == gdcm_pkg::CMD_QUERY
         && (CW'(command.tile_x) >= wu || CW'(command.tile_y) >= hu)) |=> done)
        else $error("out-of-map query did not answer at once");

    // The recompute phase counter stays within one tile's schedule.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FWD || state_reg == ST_BWD) |-> phase_reg <= PH_LAST)
        else $error("recompute phase out of range");

    // The grid is written only by the clearing pass and by rectangle transactions.
    assert property (@(posedge clk) disable iff (!rst_n)
        g_we |-> (state_reg == ST_CLEAR || state_reg == ST_RECT))
        else $error("unexpected grid write");

endmodule

`default_nettype wire

@@ dv/grid_directional_clearance_map_core_tb.sv @@
// Self-checking testbench for the eight-direction clearance map core.
module grid_directional_clearance_map_core_tb;

    localparam int SIDE     = 128;
    localparam int CAP      = 20;
    localparam int WD_LIMIT = 1000000;

    typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_DRAIN, ENT_MODE} entry_kind_t;

    typedef struct {
        entry_kind_t         kind;
        gdcm_pkg::command_t  item;
        logic                reg_index;
        logic [7:0]          reg_value;
        int                  idle_pct;
    } entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    gdcm_pkg::command_t command = '0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_data = 8'd0;
    logic               busy;
    logic               done;
    gdcm_pkg::result_t  result;

    grid_directional_clearance_map_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .busy(busy), .done(done), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the grid, the runs and the size registers.
    bit         grid_bits [0:SIDE*SIDE-1];
    logic [7:0] run_mem [0:SIDE*SIDE*8-1];
    logic [7:0] width_reg = 8'd128;
    logic [7:0] height_reg = 8'd128;

    entry_t             pending_q[$];
    gdcm_pkg::result_t  expected_results[$];
    int                 mismatches = 0;
    int                 sender_idle_pct = 0;
    int                 quiet_cycles = 0;

    // Direction steps in the order N, S, W, E, NW, NE, SW, SE.
    int dir_dx [0:7] = '{0, 0, -1, 1, -1, 1, -1, 1};
    int dir_dy [0:7] = '{-1, 1, 0, 0, -1, -1, 1, 1};

    function automatic int side_in_use(input logic [7:0] v);
        if (v == 8'd0)
            return 1;
        if (v > SIDE)
            return SIDE;
        return int'(v);
    endfunction

    function automatic int neighbor_run(input int x, input int y, input int d,
                                        input int w, input int h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 0;
        return int'(run_mem[(y*SIDE + x)*8 + d]);
    endfunction

    // Compute one half of a tile's runs from its already-scanned neighbors.
    task automatic fill_tile(input int x, input int y, input bit bwd, input int w, input int h);
        int d;
        int v;
        for (int k = 0; k < 4; k++)
        begin
            d = int'(gdcm_pkg::dir_of(bwd, 2'(k)));
            v = 0;
            if (grid_bits[y*SIDE + x])
            begin
                v = 1 + neighbor_run(x + dir_dx[d], y + dir_dy[d], d, w, h);
                if (v > 255)
                    v = 255;
            end
            run_mem[(y*SIDE + x)*8 + d] = 8'(v);
        end
    endtask

    task automatic rebuild_runs(input int w, input int h);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                fill_tile(x, y, 1'b0, w, h);
        for (int y = h - 1; y >= 0; y--)
            for (int x = w - 1; x >= 0; x--)
                fill_tile(x, y, 1'b1, w, h);
    endtask

    // Apply one command to the shadow state and return its result.
    task automatic predict_clearance(input gdcm_pkg::command_t c,
                                     output gdcm_pkg::result_t r);
        int w;
        int h;
        int x_end;
        int y_end;
        int base;
        int prox;
        int pw;
        int s;
        bit any;
        w = side_in_use(width_reg);
        h = side_in_use(height_reg);
        r = '0;
        any = 1'b0;
        if (c.cmd == gdcm_pkg::CMD_LOAD || c.cmd == gdcm_pkg::CMD_UPDATE)
        begin
            x_end = int'(c.tile_x) + int'(c.rect_w);
            y_end = int'(c.tile_y) + int'(c.rect_h);
            if (x_end > w)
                x_end = w;
            if (y_end > h)
                y_end = h;
            for (int y = int'(c.tile_y); y < y_end; y++)
                for (int x = int'(c.tile_x); x < x_end; x++)
                    if (grid_bits[y*SIDE + x] != c.walkable)
                    begin
                        grid_bits[y*SIDE + x] = c.walkable;
                        any = 1'b1;
                    end
            if (c.cmd == gdcm_pkg::CMD_UPDATE && any)
                rebuild_runs(w, h);
            r.changed = any;
        end
        else if (c.cmd == gdcm_pkg::CMD_QUERY && int'(c.tile_x) < w && int'(c.tile_y) < h)
        begin
            base = (int'(c.tile_y)*SIDE + int'(c.tile_x))*8;
            prox = CAP;
            for (int d = 0; d < 8; d++)
                if (int'(run_mem[base + d]) < prox)
                    prox = int'(run_mem[base + d]);
            pw = int'(run_mem[base + gdcm_pkg::DIR_N]) + int'(run_mem[base + gdcm_pkg::DIR_S]);
            s = int'(run_mem[base + gdcm_pkg::DIR_W]) + int'(run_mem[base + gdcm_pkg::DIR_E]);
            if (s < pw)
                pw = s;
            s = int'(run_mem[base + gdcm_pkg::DIR_NE]) + int'(run_mem[base + gdcm_pkg::DIR_SW]);
            if (s < pw)
                pw = s;
            s = int'(run_mem[base + gdcm_pkg::DIR_NW]) + int'(run_mem[base + gdcm_pkg::DIR_SE]);
            if (s < pw)
                pw = s;
            if (pw > 511)
                pw = 511;
            r.tile_walkable = grid_bits[base/8];
            r.proximity = 5'(prox);
            r.passage_width = 9'(pw);
        end
    endtask

    // Queue helpers for the stimulus.
    task automatic add_cmd(input logic [1:0] cmd, input int x, input int y,
                           input int rw, input int rh, input bit wv);
        entry_t e;
        e = '{kind: ENT_ITEM, item: '0, reg_index: 1'b0, reg_value: 8'd0, idle_pct: 0};
        e.item.cmd = cmd;
        e.item.tile_x = 7'(x);
        e.item.tile_y = 7'(y);
        e.item.rect_w = 5'(rw);
        e.item.rect_h = 5'(rh);
        e.item.walkable = wv;
        pending_q.push_back(e);
    endtask

    task automatic add_ctrl(input entry_kind_t kind, input logic idx, input int value);
        entry_t e;
        e = '{kind: kind, item: '0, reg_index: idx, reg_value: 8'(value), idle_pct: value};
        pending_q.push_back(e);
    endtask

    // Mostly well-formed commands inside the map, with some noise outside it.
    task automatic add_random_cmds(input int count, input int w, input int h);
        int roll;
        logic [1:0] cmd;
        int x;
        int y;
        int rw;
        int rh;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                cmd = gdcm_pkg::CMD_QUERY;
            else if (roll < 75)
                cmd = gdcm_pkg::CMD_UPDATE;
            else if (roll < 95)
                cmd = gdcm_pkg::CMD_LOAD;
            else
                cmd = gdcm_pkg::CMD_NOP;
            x = ($urandom_range(0, 99) < 85) ? $urandom_range(0, w - 1) : $urandom_range(0, 127);
            y = ($urandom_range(0, 99) < 85) ? $urandom_range(0, h - 1) : $urandom_range(0, 127);
            rw = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16) : $urandom_range(0, 31);
            rh = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16) : $urandom_range(0, 31);
            add_cmd(cmd, x, y, rw, rh, $urandom_range(0, 99) < 65);
            if ($urandom_range(0, 99) < 4)
                add_ctrl(ENT_DRAIN, 1'b0, 0);
        end
    endtask

    // Clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Driver: one queued transaction or register write per cycle, unless busy.
    always @(posedge clk)
    begin
        gdcm_pkg::result_t r;
        entry_t            e;
        logic              we_v;
        we_v = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_clearance(command, r);
                expected_results.push_back(r);
            end
            if (start && busy)
                start <= 1'b1;
            else if (pending_q.size() == 0)
                start <= 1'b0;
            else
            begin
                case (pending_q[0].kind)
                    ENT_MODE:
                    begin
                        sender_idle_pct = pending_q[0].idle_pct;
                        void'(pending_q.pop_front());
                        start <= 1'b0;
                    end
                    ENT_DRAIN:
                    begin
                        if (expected_results.size() == 0 && !busy && !start)
                            void'(pending_q.pop_front());
                        start <= 1'b0;
                    end
                    ENT_CFG:
                    begin
                        if (expected_results.size() == 0 && !busy && !start)
                        begin
                            we_v = 1'b1;
                            cfg_index <= pending_q[0].reg_index;
                            cfg_data <= pending_q[0].reg_value;
                            if (pending_q[0].reg_index == gdcm_pkg::REG_MAP_WIDTH)
                                width_reg = pending_q[0].reg_value;
                            else
                                height_reg = pending_q[0].reg_value;
                            void'(pending_q.pop_front());
                        end
                        start <= 1'b0;
                    end
                    default:
                    begin
                        if ($urandom_range(0, 99) < sender_idle_pct)
                            start <= 1'b0;
                        else
                        begin
                            e = pending_q.pop_front();
                            start <= 1'b1;
                            command <= e.item;
                        end
                    end
                endcase
            end
        end
        cfg_we <= we_v;
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        gdcm_pkg::result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no expectation waiting");
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result.changed !== exp_r.changed)
                begin
                    $error("changed: expected %0d, actual %0d", exp_r.changed, result.changed);
                    mismatches++;
                end
                if (result.tile_walkable !== exp_r.tile_walkable)
                begin
                    $error("tile_walkable: expected %0d, actual %0d",
                           exp_r.tile_walkable, result.tile_walkable);
                    mismatches++;
                end
                if (result.proximity !== exp_r.proximity)
                begin
                    $error("proximity: expected %0d, actual %0d",
                           exp_r.proximity, result.proximity);
                    mismatches++;
                end
                if (result.passage_width !== exp_r.passage_width)
                begin
                    $error("passage_width: expected %0d, actual %0d",
                           exp_r.passage_width, result.passage_width);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without a start taken, a result or a register write.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus and end of test.
    initial
    begin
        for (int i = 0; i < SIDE*SIDE; i++)
            grid_bits[i] = 1'b0;
        for (int i = 0; i < SIDE*SIDE*8; i++)
            run_mem[i] = 8'd0;

        // Directed part on the full-size map after reset.
        add_ctrl(ENT_MODE, 1'b0, 11);
        add_cmd(gdcm_pkg::CMD_QUERY, 0, 0, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_QUERY, 127, 127, 31, 31, 1'b1);
        add_cmd(gdcm_pkg::CMD_LOAD, 0, 0, 16, 16, 1'b1);
        add_cmd(gdcm_pkg::CMD_QUERY, 3, 3, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_UPDATE, 0, 0, 16, 16, 1'b1);
        add_cmd(gdcm_pkg::CMD_UPDATE, 5, 5, 0, 4, 1'b0);
        add_cmd(gdcm_pkg::CMD_NOP, 127, 127, 31, 31, 1'b1);
        add_cmd(gdcm_pkg::CMD_UPDATE, 120, 124, 31, 31, 1'b1);
        add_cmd(gdcm_pkg::CMD_QUERY, 127, 127, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_QUERY, 8, 8, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_QUERY, 15, 0, 1, 1, 1'b0);
        add_ctrl(ENT_DRAIN, 1'b0, 0);

        // Small map, full fill, out-of-map query and a hole.
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_WIDTH, 8);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_HEIGHT, 8);
        add_cmd(gdcm_pkg::CMD_UPDATE, 0, 0, 31, 31, 1'b1);
        add_cmd(gdcm_pkg::CMD_QUERY, 0, 0, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_QUERY, 4, 3, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_QUERY, 8, 2, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_UPDATE, 8, 8, 4, 4, 1'b0);
        add_cmd(gdcm_pkg::CMD_LOAD, 3, 3, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_QUERY, 3, 3, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_UPDATE, 6, 1, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_QUERY, 3, 3, 1, 1, 1'b0);
        add_cmd(gdcm_pkg::CMD_QUERY, 4, 4, 1, 1, 1'b0);

        // Random part over several map sizes, the degenerate ones among them.
        add_random_cmds(12, 8, 8);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_WIDTH, 0);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_HEIGHT, 1);
        add_random_cmds(8, 1, 1);
        add_ctrl(ENT_MODE, 1'b0, 80);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_WIDTH, 16);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_HEIGHT, 5);
        add_random_cmds(25, 16, 5);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_WIDTH, 255);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_HEIGHT, 2);
        add_random_cmds(10, 128, 2);
        add_ctrl(ENT_MODE, 1'b0, 0);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_WIDTH, 3);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_HEIGHT, 200);
        add_random_cmds(10, 3, 128);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_WIDTH, 12);
        add_ctrl(ENT_CFG, gdcm_pkg::REG_MAP_HEIGHT, 12);
        add_random_cmds(35, 12, 12);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && expected_results.size() == 0 && !start);
        repeat (40) @(posedge clk);
        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
